// ===== sv/pgt_pkg.sv =====
`timescale 1ns / 1ps
package pgt_pkg;
	localparam int TableDepth = 256;
	localparam int KindCount = 16;
	localparam int PosW = $clog2(TableDepth);
	localparam int CntW = PosW + 1;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_FIND_KU = 3'd2,
		OP_FIND_ACC = 3'd3,
		OP_FIND_AK = 3'd4,
		OP_FIND_ADDR = 3'd5,
		OP_FIND_OVL = 3'd6,
		OP_UNUSED = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_INVALID = 2'd2,
		ST_OVERLAP = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] res_kind;
		logic addr_kind;
		logic [15:0] user_num;
		logic [30:0] account;
		logic [31:0] ip_addr;
		logic [5:0] prefix_len;
		logic [8:0] start_pos;
		logic [7:0] entry_pos;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] hit_pos;
		logic [3:0] hit_kind;
		logic [15:0] hit_user;
		logic [30:0] hit_account;
		logic [8:0] entry_count;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_OVL_RD, S_OVL_CMP, S_MAX_RD, S_MAX_CMP,
		S_WRITE, S_DEL_RD, S_DEL_WR, S_SRCH_RD, S_SRCH_CMP, S_HIT_RD,
		S_HIT_CAP, S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the request and its prefix mask, clear the user maximum
		logic set_idx;    // load the scan index
		logic [1:0] idx_src; // 0 zero, 1 start_pos, 2 entry_pos
		logic idx_inc;
		logic rd;         // read the memories at the scan index
		logic rd_next;    // read at scan index + 1
		logic max_upd;    // fold the read entry into the user maximum
		logic wr_ins;     // append the new entry
		logic wr_shift;   // write the read entry at the scan index
		logic dec_cnt;
		logic cap_hit;    // latch hit fields from the read data
		logic [1:0] status;
		logic set_status;
		logic [7:0] pad;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic insert_bad;   // full, kind range or prefix invalid
		logic ovl_prefix_bad;
		logic del_bad;
		logic idx_end;      // scan index has reached the entry count
		logic idx_last;     // scan index + 1 has reached the entry count
		logic ovl_hit;
		logic srch_hit;
		logic user_full;
	} sts_t;

	function automatic logic [31:0] prefix_mask(input logic [5:0] bits);
		logic [31:0] m;
		m = '0;
		if (bits >= 6'd32) m = '1;
		else if (bits != 6'd0) m = ~(32'hffff_ffff >> bits);
		return m;
	endfunction
endpackage

// ===== sv/pgt_ctrl.sv =====
`timescale 1ns / 1ps
module pgt_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic [2:0] op,
	input logic out_taken,
	input pgt_pkg::sts_t sts,
	output logic busy,
	output logic out_valid,
	output pgt_pkg::cmd_t cmd
);
	pgt_pkg::state_t state_q, state_d;
	logic [2:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pgt_pkg::S_IDLE;
			op_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_fire) op_q <= op;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pgt_pkg::S_IDLE: if (in_fire) state_d = pgt_pkg::S_CHECK;
			pgt_pkg::S_CHECK: begin
				unique case (op_q)
					pgt_pkg::OP_INSERT: begin
						if (sts.insert_bad) state_d = pgt_pkg::S_OUT;
						else state_d = pgt_pkg::S_OVL_RD;
					end
					pgt_pkg::OP_DELETE: begin
						if (sts.del_bad) state_d = pgt_pkg::S_OUT;
						else state_d = pgt_pkg::S_HIT_RD;
					end
					pgt_pkg::OP_FIND_KU, pgt_pkg::OP_FIND_ACC, pgt_pkg::OP_FIND_AK,
					pgt_pkg::OP_FIND_ADDR: state_d = pgt_pkg::S_SRCH_RD;
					pgt_pkg::OP_FIND_OVL: begin
						if (sts.ovl_prefix_bad) state_d = pgt_pkg::S_OUT;
						else state_d = pgt_pkg::S_SRCH_RD;
					end
					default: state_d = pgt_pkg::S_OUT;
				endcase
			end
			pgt_pkg::S_OVL_RD: begin
				if (sts.idx_end) state_d = pgt_pkg::S_MAX_RD;
				else state_d = pgt_pkg::S_OVL_CMP;
			end
			pgt_pkg::S_OVL_CMP: begin
				if (sts.ovl_hit) state_d = pgt_pkg::S_HIT_CAP;
				else state_d = pgt_pkg::S_OVL_RD;
			end
			pgt_pkg::S_MAX_RD: begin
				if (sts.idx_end) state_d = pgt_pkg::S_WRITE;
				else state_d = pgt_pkg::S_MAX_CMP;
			end
			pgt_pkg::S_MAX_CMP: state_d = pgt_pkg::S_MAX_RD;
			pgt_pkg::S_WRITE: begin
				if (sts.user_full) state_d = pgt_pkg::S_OUT;
				else state_d = pgt_pkg::S_HIT_RD;
			end
			pgt_pkg::S_HIT_RD: state_d = pgt_pkg::S_HIT_CAP;
			pgt_pkg::S_HIT_CAP: begin
				if (op_q == pgt_pkg::OP_DELETE) state_d = pgt_pkg::S_DEL_RD;
				else state_d = pgt_pkg::S_OUT;
			end
			pgt_pkg::S_DEL_RD: begin
				if (sts.idx_last) state_d = pgt_pkg::S_OUT;
				else state_d = pgt_pkg::S_DEL_WR;
			end
			pgt_pkg::S_DEL_WR: state_d = pgt_pkg::S_DEL_RD;
			pgt_pkg::S_SRCH_RD: begin
				if (sts.idx_end) state_d = pgt_pkg::S_OUT;
				else state_d = pgt_pkg::S_SRCH_CMP;
			end
			pgt_pkg::S_SRCH_CMP: begin
				if (sts.srch_hit) state_d = pgt_pkg::S_HIT_CAP;
				else state_d = pgt_pkg::S_SRCH_RD;
			end
			pgt_pkg::S_OUT: if (out_taken) state_d = pgt_pkg::S_IDLE;
			default: state_d = pgt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != pgt_pkg::S_IDLE);
		out_valid = (state_q == pgt_pkg::S_OUT);
		unique case (state_q)
			pgt_pkg::S_IDLE: cmd.load = in_fire;
			pgt_pkg::S_CHECK: begin
				cmd.set_idx = 1'b1;
				cmd.set_status = 1'b1;
				unique case (op_q)
					pgt_pkg::OP_INSERT: begin
						cmd.idx_src = 2'd0;
						cmd.status = pgt_pkg::ST_INVALID;
					end
					pgt_pkg::OP_DELETE: begin
						cmd.idx_src = 2'd2;
						cmd.status = sts.del_bad ? pgt_pkg::ST_INVALID : pgt_pkg::ST_DONE;
					end
					pgt_pkg::OP_FIND_KU, pgt_pkg::OP_FIND_ACC, pgt_pkg::OP_FIND_AK,
					pgt_pkg::OP_FIND_ADDR: begin
						cmd.idx_src = 2'd1;
						cmd.status = pgt_pkg::ST_NOT_FOUND;
					end
					pgt_pkg::OP_FIND_OVL: begin
						cmd.idx_src = 2'd1;
						cmd.status = sts.ovl_prefix_bad ? pgt_pkg::ST_INVALID
							: pgt_pkg::ST_NOT_FOUND;
					end
					default: cmd.status = pgt_pkg::ST_INVALID;
				endcase
			end
			pgt_pkg::S_OVL_RD: begin
				cmd.rd = 1'b1;
				if (sts.idx_end) begin
					cmd.set_idx = 1'b1;
					cmd.idx_src = 2'd0;
				end
			end
			pgt_pkg::S_OVL_CMP: begin
				cmd.idx_inc = !sts.ovl_hit;
				if (sts.ovl_hit) begin
					cmd.set_status = 1'b1;
					cmd.status = pgt_pkg::ST_OVERLAP;
				end
			end
			pgt_pkg::S_MAX_RD: cmd.rd = 1'b1;
			pgt_pkg::S_MAX_CMP: begin
				cmd.max_upd = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			pgt_pkg::S_WRITE: begin
				cmd.wr_ins = !sts.user_full;
				if (!sts.user_full) begin
					cmd.set_status = 1'b1;
					cmd.status = pgt_pkg::ST_DONE;
				end
			end
			pgt_pkg::S_HIT_RD: cmd.rd = 1'b1;
			pgt_pkg::S_HIT_CAP: cmd.cap_hit = 1'b1;
			pgt_pkg::S_DEL_RD: begin
				cmd.rd_next = 1'b1;
				cmd.dec_cnt = sts.idx_last;
			end
			pgt_pkg::S_DEL_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			pgt_pkg::S_SRCH_RD: cmd.rd = 1'b1;
			pgt_pkg::S_SRCH_CMP: begin
				cmd.idx_inc = !sts.srch_hit;
				if (sts.srch_hit) begin
					cmd.set_status = 1'b1;
					cmd.status = pgt_pkg::ST_DONE;
				end
			end
			pgt_pkg::S_OUT: cmd = '0;
			default: cmd = '0;
		endcase
	end
endmodule

// ===== sv/pgt_dp.sv =====
`timescale 1ns / 1ps
module pgt_dp (
	input logic clk,
	input logic arst_n,
	input pgt_pkg::req_t req,
	input pgt_pkg::cmd_t cmd,
	output pgt_pkg::sts_t sts,
	output pgt_pkg::rsp_t rsp
);
	localparam int PW = pgt_pkg::PosW;
	localparam int CW = pgt_pkg::CntW;

	logic [3:0] mem_kind [pgt_pkg::TableDepth];
	logic [15:0] mem_user [pgt_pkg::TableDepth];
	logic [30:0] mem_acc [pgt_pkg::TableDepth];
	logic [31:0] mem_addr [pgt_pkg::TableDepth];
	logic [31:0] mem_mask [pgt_pkg::TableDepth];

	pgt_pkg::req_t req_q;
	logic [CW-1:0] count_q, idx_q;
	logic [31:0] mask_q;
	logic [1:0] status_q;
	logic any_q;
	logic [15:0] hi_q;
	logic [3:0] rd_kind_q;
	logic [15:0] rd_user_q;
	logic [30:0] rd_acc_q;
	logic [31:0] rd_addr_q, rd_mask_q;
	logic [7:0] hit_pos_q;
	logic [3:0] hit_kind_q;
	logic [15:0] hit_user_q;
	logic [30:0] hit_acc_q;

	logic [CW-1:0] idx_nx;
	logic [PW-1:0] rd_a;
	logic [31:0] ovl_m;
	logic is_ins, full_bad, kind_bad, pfx_bad;

	assign idx_nx = idx_q + CW'(1);
	assign rd_a = cmd.rd_next ? idx_nx[PW-1:0] : idx_q[PW-1:0];
	assign ovl_m = mask_q & rd_mask_q;
	assign is_ins = req_q.addr_kind;
	assign full_bad = (count_q >= CW'(pgt_pkg::TableDepth));
	assign kind_bad = (32'(req_q.res_kind) >= 32'(pgt_pkg::KindCount));
	assign pfx_bad = is_ins && ((req_q.prefix_len > 6'd32)
		|| ((req_q.ip_addr & pgt_pkg::prefix_mask(req_q.prefix_len)) != req_q.ip_addr));

	always_comb begin
		sts.insert_bad = full_bad || kind_bad || pfx_bad;
		sts.ovl_prefix_bad = (req_q.prefix_len > 6'd32);
		sts.del_bad = ({1'b0, req_q.entry_pos} >= count_q);
		sts.idx_end = (idx_q >= count_q);
		sts.idx_last = (idx_nx >= count_q);
		sts.ovl_hit = is_ins && (rd_mask_q != '0)
			&& ((rd_addr_q & ovl_m) == (req_q.ip_addr & ovl_m));
		sts.user_full = any_q && (hi_q == 16'hffff);
		sts.srch_hit = 1'b0;
		case (req_q.op)
			pgt_pkg::OP_FIND_KU: sts.srch_hit = (rd_kind_q == req_q.res_kind)
				&& (rd_user_q == req_q.user_num);
			pgt_pkg::OP_FIND_ACC: sts.srch_hit = (rd_acc_q == req_q.account);
			pgt_pkg::OP_FIND_AK: sts.srch_hit = (rd_acc_q == req_q.account)
				&& (rd_kind_q == req_q.res_kind);
			pgt_pkg::OP_FIND_ADDR: sts.srch_hit = (rd_mask_q != '0)
				&& (rd_addr_q == (req_q.ip_addr & rd_mask_q));
			pgt_pkg::OP_FIND_OVL: sts.srch_hit = (rd_mask_q != '0)
				&& ((rd_addr_q & ovl_m) == (req_q.ip_addr & ovl_m));
			default: sts.srch_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.rd || cmd.rd_next) begin
			rd_kind_q <= mem_kind[rd_a];
			rd_user_q <= mem_user[rd_a];
			rd_acc_q <= mem_acc[rd_a];
			rd_addr_q <= mem_addr[rd_a];
			rd_mask_q <= mem_mask[rd_a];
		end
		if (cmd.wr_ins) begin
			mem_kind[count_q[PW-1:0]] <= req_q.res_kind;
			mem_user[count_q[PW-1:0]] <= any_q ? hi_q + 16'd1 : 16'd0;
			mem_acc[count_q[PW-1:0]] <= req_q.account;
			mem_addr[count_q[PW-1:0]] <= is_ins ? req_q.ip_addr : 32'd0;
			mem_mask[count_q[PW-1:0]] <= mask_q;
		end else if (cmd.wr_shift) begin
			mem_kind[idx_q[PW-1:0]] <= rd_kind_q;
			mem_user[idx_q[PW-1:0]] <= rd_user_q;
			mem_acc[idx_q[PW-1:0]] <= rd_acc_q;
			mem_addr[idx_q[PW-1:0]] <= rd_addr_q;
			mem_mask[idx_q[PW-1:0]] <= rd_mask_q;
		end
		if (cmd.load) req_q <= req;
		if (cmd.cap_hit) begin
			hit_pos_q <= 8'(idx_q);
			hit_kind_q <= rd_kind_q;
			hit_user_q <= rd_user_q;
			hit_acc_q <= rd_acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q <= '0;
			mask_q <= '0;
			status_q <= '0;
			any_q <= 1'b0;
			hi_q <= '0;
		end else begin
			if (cmd.load) begin
				any_q <= 1'b0;
				hi_q <= '0;
				// The overlap search uses its own prefix whatever the kind flag says.
				mask_q <= (req.addr_kind || req.op == pgt_pkg::OP_FIND_OVL)
					? pgt_pkg::prefix_mask(req.prefix_len) : 32'd0;
			end
			if (cmd.set_idx) begin
				case (cmd.idx_src)
					2'd1: idx_q <= CW'(req_q.start_pos);
					2'd2: idx_q <= CW'(req_q.entry_pos);
					default: idx_q <= '0;
				endcase
			end else if (cmd.idx_inc) begin
				idx_q <= idx_nx;
			end else if (cmd.wr_ins) begin
				idx_q <= count_q;
			end
			if (cmd.max_upd && rd_kind_q == req_q.res_kind
				&& (!any_q || rd_user_q > hi_q)) begin
				any_q <= 1'b1;
				hi_q <= rd_user_q;
			end
			if (cmd.wr_ins) count_q <= count_q + CW'(1);
			if (cmd.dec_cnt) count_q <= count_q - CW'(1);
			if (cmd.set_status) status_q <= cmd.status;
		end
	end

	always_comb begin
		rsp.status = status_q;
		rsp.entry_count = 9'(count_q);
		if (status_q == pgt_pkg::ST_DONE || status_q == pgt_pkg::ST_OVERLAP) begin
			rsp.hit_pos = hit_pos_q;
			rsp.hit_kind = hit_kind_q;
			rsp.hit_user = hit_user_q;
			rsp.hit_account = hit_acc_q;
		end else begin
			rsp.hit_pos = '0;
			rsp.hit_kind = '0;
			rsp.hit_user = '0;
			rsp.hit_account = '0;
		end
	end
endmodule

// ===== sv/prefix_gate_table.sv =====
`timescale 1ns / 1ps
// A request is checked first, and a rejected one goes straight to the result. A search reads
// on from its start position, a delete shifts the entries above its position down, and an
// insert scans for overlap and the user maximum before it appends; the entry count is at most 256.
// Throughput: one item at a time; the next item can be accepted in the cycle after the result
// is taken, and the controller walks the table with a read state and a compare or write state per entry.
// Reset: arst_n clears the entry count and controller; entry contents stay undefined.
module prefix_gate_table (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input pgt_pkg::req_t in_data,
	output logic out_valid,
	input logic out_stall,
	output pgt_pkg::rsp_t out_data
);
	pgt_pkg::cmd_t cmd;
	pgt_pkg::sts_t sts;
	logic busy;

	assign in_stall = busy;

	pgt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(in_valid && !busy), .op(in_data.op),
		.out_taken(!out_stall), .sts(sts),
		.busy(busy), .out_valid(out_valid), .cmd(cmd)
	);

	pgt_dp u_dp (
		.clk(clk), .arst_n(arst_n), .req(in_data),
		.cmd(cmd), .sts(sts), .rsp(out_data)
	);
endmodule

// ===== sv/pgt_checker.sv =====
`timescale 1ns / 1ps
module pgt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input pgt_pkg::rsp_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result item waits");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("block not busy after taking an item");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == pgt_pkg::ST_NOT_FOUND
		|| out_data.status == pgt_pkg::ST_INVALID) |-> out_data.hit_pos == '0)
		else $error("hit position set on a miss");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.entry_count <= 9'd256)
		else $error("entry count out of range");
endmodule

bind prefix_gate_table pgt_checker u_pgt_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
